[design/cslc_pkg.sv]
// Shared types and constants for the cone and line-of-sight checker.
// No dependencies; imported by every module of the block except the map memory.
`timescale 1ns / 1ps

package cslc_pkg;

    // result codes
    localparam logic [2:0] OC_SEEN    = 3'd0;
    localparam logic [2:0] OC_RANGE   = 3'd1;
    localparam logic [2:0] OC_CONE    = 3'd2;
    localparam logic [2:0] OC_BLOCKED = 3'd3;
    localparam logic [2:0] OC_OFFMAP  = 3'd4;
    localparam logic [2:0] OC_WRITE   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RANGE_SQ   = 2'd2;
    localparam logic [1:0] CFG_CONE_COS   = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int MAC_W = 42;

    typedef struct packed {
        logic [6:0]  col_count;
        logic [6:0]  row_count;
        logic [13:0] range_sq;
        logic [16:0] cone_cos_sq;
    } t_cfg;

    // one multiply-accumulate step
    typedef struct packed {
        logic               en;
        logic               acc;    // 1: add to accumulator, 0: load
        logic               shift;  // product shifted left by 12
        logic signed [17:0] a;
        logic signed [17:0] b;
    } t_mac_cmd;

endpackage

[design/cslc_mac.sv]
// Shared signed 18x18 multiply-accumulate unit with a 42-bit accumulator.
// Depends on cslc_pkg (t_mac_cmd, MAC_W).
`timescale 1ns / 1ps

module cslc_mac import cslc_pkg::*; (
    input  logic                    i_clk,
    input  t_mac_cmd                i_cmd,
    output logic signed [MAC_W-1:0] o_acc
);

    logic signed [35:0]      w_prod;
    logic signed [MAC_W-1:0] w_addend;
    logic signed [MAC_W-1:0] r_acc;

    assign w_prod   = i_cmd.a * i_cmd.b;
    assign w_addend = i_cmd.shift ? (MAC_W'(w_prod) <<< 12) : MAC_W'(w_prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_acc <= (i_cmd.acc ? r_acc : '0) + w_addend;
        end
    end

    assign o_acc = r_acc;

endmodule

[design/cslc_map_mem.sv]
// One-bit obstacle map: single write port, one registered read port.
// No package dependency.
`timescale 1ns / 1ps

module cslc_map_mem #(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [(1 << AW)];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/cslc_seq.sv]
// Sequencer: map clear pass, cell writes, cone test steps on the shared MAC,
// and the one-cell-per-cycle Bresenham walk. Depends on cslc_pkg.
`timescale 1ns / 1ps

module cslc_seq import cslc_pkg::*; #(
    parameter int GRID_SIDE = 64,
    parameter int CW        = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    // input words
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_operation,
    input  logic [5:0]              i_cell_x,
    input  logic [5:0]              i_cell_y,
    input  logic                    i_cell_blocked,
    input  logic [5:0]              i_agent_x,
    input  logic [5:0]              i_agent_y,
    input  logic [5:0]              i_target_x,
    input  logic [5:0]              i_target_y,
    input  logic signed [4:0]       i_facing_x,
    input  logic signed [4:0]       i_facing_y,
    // result words
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_visible,
    output logic [2:0]              o_outcome,
    output logic [7:0]              o_cells_walked,
    // shared MAC
    output t_mac_cmd                o_mac,
    input  logic signed [MAC_W-1:0] i_acc,
    // map memory
    output logic                    o_we,
    output logic [2*CW-1:0]         o_waddr,
    output logic                    o_wdata,
    output logic [2*CW-1:0]         o_raddr,
    input  logic                    i_rdata
);

    localparam int AW = 2 * CW;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_M0    = 4'd2;
    localparam logic [3:0] ST_M1    = 4'd3;
    localparam logic [3:0] ST_M2    = 4'd4;
    localparam logic [3:0] ST_M3    = 4'd5;
    localparam logic [3:0] ST_M4    = 4'd6;
    localparam logic [3:0] ST_M5    = 4'd7;
    localparam logic [3:0] ST_M6    = 4'd8;
    localparam logic [3:0] ST_M7    = 4'd9;
    localparam logic [3:0] ST_M8    = 4'd10;
    localparam logic [3:0] ST_M9    = 4'd11;
    localparam logic [3:0] ST_CMP   = 4'd12;
    localparam logic [3:0] ST_WALK  = 4'd13;
    localparam logic [3:0] ST_OUT   = 4'd14;

    logic [3:0]        r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [5:0]        r_ax, n_ax, r_ay, n_ay, r_tx, n_tx, r_ty, n_ty;
    logic signed [4:0] r_fx, n_fx, r_fy, n_fy;
    logic [12:0]       r_dist, n_dist;
    logic [11:0]       r_dot, n_dot;
    logic [9:0]        r_dir, n_dir;
    logic [21:0]       r_lhs, n_lhs;
    logic [22:0]       r_t, n_t;
    logic [5:0]        r_x, n_x, r_y, n_y;
    logic signed [8:0] r_err, n_err;
    logic              r_sx, n_sx, r_sy, n_sy;
    logic [6:0]        r_walked, n_walked;
    logic              r_vis, n_vis;
    logic [2:0]        r_outcome, n_outcome;

    logic signed [6:0] w_vx, w_vy;
    logic [5:0]        w_adx, w_ady;
    logic [6:0]        w_w, w_h;
    logic              w_offmap, w_at_target, w_at_agent;
    logic signed [9:0] w_e2, w_err_nx;
    logic              w_step_x, w_step_y;
    logic [5:0]        w_nx, w_ny;

    assign w_vx  = $signed({1'b0, r_tx}) - $signed({1'b0, r_ax});
    assign w_vy  = $signed({1'b0, r_ty}) - $signed({1'b0, r_ay});
    assign w_adx = w_vx[6] ? 6'(-w_vx) : w_vx[5:0];
    assign w_ady = w_vy[6] ? 6'(-w_vy) : w_vy[5:0];

    // map size saturates at the store side
    assign w_w = (32'(i_cfg.col_count) > GRID_SIDE) ? 7'(GRID_SIDE) : i_cfg.col_count;
    assign w_h = (32'(i_cfg.row_count) > GRID_SIDE) ? 7'(GRID_SIDE) : i_cfg.row_count;

    assign w_offmap    = ({1'b0, r_x} >= w_w) || ({1'b0, r_y} >= w_h);
    assign w_at_target = (r_x == r_tx) && (r_y == r_ty);
    assign w_at_agent  = (r_x == r_ax) && (r_y == r_ay);

    // Bresenham step; dy is -|vy|
    assign w_e2     = 10'(r_err) <<< 1;
    assign w_step_x = (w_e2 >= -$signed({4'b0, w_ady}));
    assign w_step_y = (w_e2 <= $signed({4'b0, w_adx}));
    assign w_err_nx = 10'(r_err)
                    - (w_step_x ? $signed({4'b0, w_ady}) : 10'sd0)
                    + (w_step_y ? $signed({4'b0, w_adx}) : 10'sd0);
    assign w_nx = w_step_x ? (r_sx ? r_x + 6'd1 : r_x - 6'd1) : r_x;
    assign w_ny = w_step_y ? (r_sy ? r_y + 6'd1 : r_y - 6'd1) : r_y;

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_ax      = r_ax;
        n_ay      = r_ay;
        n_tx      = r_tx;
        n_ty      = r_ty;
        n_fx      = r_fx;
        n_fy      = r_fy;
        n_dist    = r_dist;
        n_dot     = r_dot;
        n_dir     = r_dir;
        n_lhs     = r_lhs;
        n_t       = r_t;
        n_x       = r_x;
        n_y       = r_y;
        n_err     = r_err;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_walked  = r_walked;
        n_vis     = r_vis;
        n_outcome = r_outcome;

        o_ready   = 1'b0;
        o_mac     = '0;
        o_we      = 1'b0;
        o_waddr   = {CW'(i_cell_y), CW'(i_cell_x)};
        o_wdata   = i_cell_blocked;
        o_raddr   = {CW'(r_y), CW'(r_x)};

        case (r_state)
            ST_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                o_wdata = 1'b0;
                n_clr   = r_clr + AW'(1);
                if (r_clr == {AW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_walked = '0;
                    n_vis    = 1'b0;
                    if (i_operation == OP_WRITE) begin
                        // cells beyond the store are dropped
                        o_we      = (32'(i_cell_x) < GRID_SIDE) && (32'(i_cell_y) < GRID_SIDE);
                        n_outcome = OC_WRITE;
                        n_state   = ST_OUT;
                    end else begin
                        n_ax    = i_agent_x;
                        n_ay    = i_agent_y;
                        n_tx    = i_target_x;
                        n_ty    = i_target_y;
                        n_fx    = i_facing_x;
                        n_fy    = i_facing_y;
                        n_state = ST_M0;
                    end
                end
            end
            ST_M0: begin
                o_mac   = '{en: 1'b1, acc: 1'b0, shift: 1'b0, a: 18'(w_vx), b: 18'(w_vx)};
                n_state = ST_M1;
            end
            ST_M1: begin
                o_mac   = '{en: 1'b1, acc: 1'b1, shift: 1'b0, a: 18'(w_vy), b: 18'(w_vy)};
                n_state = ST_M2;
            end
            ST_M2: begin
                n_dist = i_acc[12:0];
                if (i_acc[12:0] == 13'd0 || {1'b0, i_acc[12:0]} > i_cfg.range_sq) begin
                    n_outcome = OC_RANGE;
                    n_state   = ST_OUT;
                end else begin
                    o_mac   = '{en: 1'b1, acc: 1'b0, shift: 1'b0, a: 18'(r_fx), b: 18'(w_vx)};
                    n_state = ST_M3;
                end
            end
            ST_M3: begin
                o_mac   = '{en: 1'b1, acc: 1'b1, shift: 1'b0, a: 18'(r_fy), b: 18'(w_vy)};
                n_state = ST_M4;
            end
            ST_M4: begin
                n_dot = i_acc[11:0];
                if (i_acc[MAC_W-1]) begin
                    n_outcome = OC_CONE;
                    n_state   = ST_OUT;
                end else begin
                    o_mac   = '{en: 1'b1, acc: 1'b0, shift: 1'b0, a: 18'(r_fx), b: 18'(r_fx)};
                    n_state = ST_M5;
                end
            end
            ST_M5: begin
                o_mac   = '{en: 1'b1, acc: 1'b1, shift: 1'b0, a: 18'(r_fy), b: 18'(r_fy)};
                n_state = ST_M6;
            end
            ST_M6: begin
                n_dir   = i_acc[9:0];
                o_mac   = '{en: 1'b1, acc: 1'b0, shift: 1'b0, a: 18'(r_dot), b: 18'(r_dot)};
                n_state = ST_M7;
            end
            ST_M7: begin
                n_lhs   = i_acc[21:0];
                o_mac   = '{en: 1'b1, acc: 1'b0, shift: 1'b0, a: 18'(r_dir), b: 18'(r_dist)};
                n_state = ST_M8;
            end
            ST_M8: begin
                // cone * dir * dist, split into low 12 and high 11 bits
                n_t     = i_acc[22:0];
                o_mac   = '{en: 1'b1, acc: 1'b0, shift: 1'b0,
                            a: 18'(i_cfg.cone_cos_sq), b: 18'(i_acc[11:0])};
                n_state = ST_M9;
            end
            ST_M9: begin
                o_mac   = '{en: 1'b1, acc: 1'b1, shift: 1'b1,
                            a: 18'(i_cfg.cone_cos_sq), b: 18'(r_t[22:12])};
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if ({3'b0, r_lhs, 16'b0} < i_acc[40:0]) begin
                    n_outcome = OC_CONE;
                    n_state   = ST_OUT;
                end else begin
                    n_x     = r_ax;
                    n_y     = r_ay;
                    n_sx    = (r_ax < r_tx);
                    n_sy    = (r_ay < r_ty);
                    n_err   = $signed({3'b0, w_adx}) - $signed({3'b0, w_ady});
                    o_raddr = {CW'(r_ay), CW'(r_ax)};
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                // i_rdata belongs to (r_x, r_y); fetch the next cell meanwhile
                n_walked = r_walked + 7'd1;
                o_raddr  = {CW'(w_ny), CW'(w_nx)};
                if (w_offmap) begin
                    n_outcome = OC_OFFMAP;
                    n_state   = ST_OUT;
                end else if (w_at_target) begin
                    n_vis     = 1'b1;
                    n_outcome = OC_SEEN;
                    n_state   = ST_OUT;
                end else if (i_rdata && !w_at_agent) begin
                    n_outcome = OC_BLOCKED;
                    n_state   = ST_OUT;
                end else begin
                    n_x   = w_nx;
                    n_y   = w_ny;
                    n_err = 9'(w_err_nx);
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_tx      <= n_tx;
        r_ty      <= n_ty;
        r_fx      <= n_fx;
        r_fy      <= n_fy;
        r_dist    <= n_dist;
        r_dot     <= n_dot;
        r_dir     <= n_dir;
        r_lhs     <= n_lhs;
        r_t       <= n_t;
        r_x       <= n_x;
        r_y       <= n_y;
        r_err     <= n_err;
        r_sx      <= n_sx;
        r_sy      <= n_sy;
        r_walked  <= n_walked;
        r_vis     <= n_vis;
        r_outcome <= n_outcome;
    end

    assign o_valid        = (r_state == ST_OUT);
    assign o_visible      = r_vis;
    assign o_outcome      = r_outcome;
    assign o_cells_walked = 8'(r_walked);

    a_seen_walked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outcome == OC_SEEN) |-> (o_visible && o_cells_walked >= 8'd2))
        else $error("seen result without a walk of two or more cells");

    a_early_no_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome == OC_RANGE || o_outcome == OC_CONE ||
                     o_outcome == OC_WRITE))
        |-> (o_cells_walked == 8'd0 && !o_visible))
        else $error("early result carries a walk count or visible flag");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!o_ready && !o_valid && o_we))
        else $error("handshake active during map clear");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_walked < 7'd64))
        else $error("line walk ran past the longest possible line");

endmodule

[design/cone_and_line_of_sight_check.sv]
// Top level of the cone and line-of-sight checker: configuration registers
// and the sequencer, shared MAC and obstacle map. Depends on cslc_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_valid/o_ready) takes one word per item: a map cell write
//   (operation 0) or a visibility query (operation 1). Each item gives exactly
//   one result word on the output channel (o_valid/i_ready).
//   Config channel (i_cfg_valid/o_cfg_ready) is always ready; index 0 map
//   width, 1 map height, 2 squared range, 3 squared cone cosine (Q1.16).
//   Write it only while no item is in flight.
// Result paths:
//   cell write: result valid in the cycle after it is accepted.
//   query rejected on range, behind, or outside cone: ends before the walk.
//   query walked: visits N cells, N = 1..64. The cone test
//   runs as ten steps on one shared 18x18 multiply-accumulate unit; the
//   walk reads one map cell per cycle from the single read port.
//   One item at a time: o_ready is high only when idle, so a new item is
//   taken only after the result word of the last one has been taken.
// Reset: registers take their reset values and the obstacle map is cleared
//   by a pass over all GRID_SIDE^2 cells (4096 at 64, rounded up to a power of two
//   per side) during which o_ready stays low; config writes are still taken.
// Stall: a result word holds on the outputs until i_ready takes it.
module cone_and_line_of_sight_check import cslc_pkg::*; #(
    parameter int GRID_SIDE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [16:0]       i_cfg_data,
    // input words
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_operation,
    input  logic [5:0]        i_cell_x,
    input  logic [5:0]        i_cell_y,
    input  logic              i_cell_blocked,
    input  logic [5:0]        i_agent_x,
    input  logic [5:0]        i_agent_y,
    input  logic [5:0]        i_target_x,
    input  logic [5:0]        i_target_y,
    input  logic signed [4:0] i_facing_x,
    input  logic signed [4:0] i_facing_y,
    // result words
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_visible,
    output logic [2:0]        o_outcome,
    output logic [7:0]        o_cells_walked
);

    localparam int CW = $clog2(GRID_SIDE);
    localparam int AW = 2 * CW;

    t_cfg                    r_cfg;
    t_mac_cmd                w_mac;
    logic signed [MAC_W-1:0] w_acc;
    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic                    w_wdata;
    logic [AW-1:0]           w_raddr;
    logic                    w_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.col_count   <= 7'd64;
            r_cfg.row_count   <= 7'd64;
            r_cfg.range_sq    <= 14'd25;
            r_cfg.cone_cos_sq <= 17'd32768;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAP_WIDTH:  r_cfg.col_count   <= i_cfg_data[6:0];
                CFG_MAP_HEIGHT: r_cfg.row_count   <= i_cfg_data[6:0];
                CFG_RANGE_SQ:   r_cfg.range_sq    <= i_cfg_data[13:0];
                CFG_CONE_COS:   r_cfg.cone_cos_sq <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cslc_seq #(
        .GRID_SIDE (GRID_SIDE),
        .CW        (CW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_cell_blocked (i_cell_blocked),
        .i_agent_x      (i_agent_x),
        .i_agent_y      (i_agent_y),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_facing_x     (i_facing_x),
        .i_facing_y     (i_facing_y),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_visible      (o_visible),
        .o_outcome      (o_outcome),
        .o_cells_walked (o_cells_walked),
        .o_mac          (w_mac),
        .i_acc          (w_acc),
        .o_we           (w_we),
        .o_waddr        (w_waddr),
        .o_wdata        (w_wdata),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata)
    );

    cslc_mac u_mac (
        .i_clk (i_clk),
        .i_cmd (w_mac),
        .o_acc (w_acc)
    );

    cslc_map_mem #(
        .AW (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule
